// ===== sv/detector_cell_to_geometry_id_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the cell to geometry identifier block
// Concurrent checks on the rising clock edge, disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef DETECTOR_CELL_TO_GEOMETRY_ID_ASSERT_SVH
`define DETECTOR_CELL_TO_GEOMETRY_ID_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define DCGID_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define DCGID_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define DCGID_ASSERT(lbl, clk, rstn, prop, msg)
`define DCGID_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== sv/dcgid_pkg.sv =====
// ---------------------------------------------------------------------------
// dcgid_pkg
// Types, subsystem codes and lookup tables for the geometry id pipeline.
// ---------------------------------------------------------------------------
package dcgid_pkg;

  localparam int unsigned VOL_W   = 8;
  localparam int unsigned LAYER_W = 28;
  localparam int unsigned SEN_W   = 56;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned LAD_W   = 10;
  localparam int unsigned PROD_W  = CNT_W + LAD_W;

  // Raw subsystem numbers from the cell identifier
  localparam logic [7:0] SYS_VTX_BAR = 8'd1;
  localparam logic [7:0] SYS_VTX_EC  = 8'd2;
  localparam logic [7:0] SYS_IN_BAR  = 8'd3;
  localparam logic [7:0] SYS_IN_EC   = 8'd4;
  localparam logic [7:0] SYS_OUT_BAR = 8'd5;
  localparam logic [7:0] SYS_OUT_EC  = 8'd6;
  localparam logic [7:0] SYS_OI_BAR  = 8'd7;
  localparam logic [7:0] SYS_OI_EC   = 8'd8;

  // Volume numbers
  localparam logic [VOL_W-1:0] VOL_VTX_BAR    = 8'd14;
  localparam logic [VOL_W-1:0] VOL_VTX_EC_POS = 8'd15;
  localparam logic [VOL_W-1:0] VOL_VTX_EC_NEG = 8'd13;
  localparam logic [VOL_W-1:0] VOL_IN_BAR     = 8'd17;
  localparam logic [VOL_W-1:0] VOL_IN_EC_POS  = 8'd18;
  localparam logic [VOL_W-1:0] VOL_IN_EC_NEG  = 8'd8;
  localparam logic [VOL_W-1:0] VOL_OUT_BAR    = 8'd24;
  localparam logic [VOL_W-1:0] VOL_OUT_EC_POS = 8'd25;
  localparam logic [VOL_W-1:0] VOL_OUT_EC_NEG = 8'd23;
  localparam logic [VOL_W-1:0] VOL_OI_BAR     = 8'd20;
  localparam logic [VOL_W-1:0] VOL_OI_EC_POS  = 8'd21;
  localparam logic [VOL_W-1:0] VOL_OI_EC_NEG  = 8'd3;

  // Ladder or ring counts
  localparam logic [CNT_W-1:0] CNT_VTX_BAR = 7'd5;
  localparam logic [CNT_W-1:0] CNT_IN_BAR  = 7'd32;
  localparam logic [CNT_W-1:0] CNT_OI_BAR  = 7'd46;
  localparam logic [CNT_W-1:0] CNT_OUT_BAR = 7'd84;
  localparam logic [CNT_W-1:0] CNT_IN_EC   = 7'd26;
  localparam logic [CNT_W-1:0] CNT_OI_EC   = 7'd26;
  localparam logic [CNT_W-1:0] CNT_OUT_EC  = 7'd48;

  localparam logic [1:0] SCHEMA_0 = 2'd0;
  localparam logic [1:0] SCHEMA_1 = 2'd1;
  localparam logic [1:0] SCHEMA_2 = 2'd2;

  typedef enum logic [3:0] {
    SUB_UNMAPPED,
    SUB_VTX_BAR,
    SUB_VTX_EC_POS,
    SUB_VTX_EC_NEG,
    SUB_IN_BAR,
    SUB_IN_EC_POS,
    SUB_IN_EC_NEG,
    SUB_OUT_BAR,
    SUB_OUT_EC_POS,
    SUB_OUT_EC_NEG,
    SUB_OI_BAR,
    SUB_OI_EC_POS,
    SUB_OI_EC_NEG
  } sub_e;

  // Decoded word
  typedef struct packed {
    sub_e             sub;
    logic [7:0]       s_byte;
    logic [7:0]       layer;
    logic [LAD_W-1:0] ladder;
    logic [LAD_W-1:0] module_idx;
    logic [1:0]       schema;
  } dec_t;

  // Looked-up word
  typedef struct packed {
    logic [VOL_W-1:0]   volume;
    logic [LAYER_W-1:0] layer_num;
    logic [SEN_W-1:0]   sen_base;
    logic               needs_cnt;
    logic               err;
    logic [PROD_W-1:0]  product;
    logic [LAD_W-1:0]   module_idx;
  } lk_t;

  function automatic logic [VOL_W-1:0] volume_of(sub_e sub, logic [7:0] s_byte);
    logic [VOL_W-1:0] v;
    case (sub)
      SUB_VTX_BAR:    v = VOL_VTX_BAR;
      SUB_VTX_EC_POS: v = VOL_VTX_EC_POS;
      SUB_VTX_EC_NEG: v = VOL_VTX_EC_NEG;
      SUB_IN_BAR:     v = VOL_IN_BAR;
      SUB_IN_EC_POS:  v = VOL_IN_EC_POS;
      SUB_IN_EC_NEG:  v = VOL_IN_EC_NEG;
      SUB_OUT_BAR:    v = VOL_OUT_BAR;
      SUB_OUT_EC_POS: v = VOL_OUT_EC_POS;
      SUB_OUT_EC_NEG: v = VOL_OUT_EC_NEG;
      SUB_OI_BAR:     v = VOL_OI_BAR;
      SUB_OI_EC_POS:  v = VOL_OI_EC_POS;
      SUB_OI_EC_NEG:  v = VOL_OI_EC_NEG;
      default:        v = s_byte;
    endcase
    return v;
  endfunction

  // Layer number, modulo 2^LAYER_W (only those bits survive the shift)
  function automatic logic [LAYER_W-1:0] layer_of(sub_e sub, logic [7:0] l,
                                                  logic [1:0] sch);
    logic [LAYER_W-1:0] lw;
    logic [LAYER_W-1:0] n;
    lw = LAYER_W'(l);
    case (sub)
      SUB_VTX_EC_NEG: n = (sch <= SCHEMA_1) ? LAYER_W'(16) - (lw << 1)
                                            : LAYER_W'(8) - lw;
      SUB_VTX_EC_POS: n = (sch <= SCHEMA_1) ? (lw << 1) + LAYER_W'(2)
                                            : lw + LAYER_W'(2);
      SUB_VTX_BAR: begin
        if (sch == SCHEMA_0) begin
          n = (lw << 1) + LAYER_W'(2);
        end else if (sch == SCHEMA_1 && l == 8'd4) begin
          n = LAYER_W'(8);
        end else if (sch == SCHEMA_1 && l == 8'd6) begin
          n = LAYER_W'(10);
        end else if (sch == SCHEMA_1 && l <= 8'd2) begin
          n = (lw << 1) + LAYER_W'(2);
        end else begin
          n = lw + LAYER_W'(2);
        end
      end
      SUB_IN_BAR, SUB_OUT_BAR, SUB_IN_EC_POS, SUB_OUT_EC_POS:
                      n = (lw << 1) + LAYER_W'(2);
      SUB_OI_BAR:     n = LAYER_W'(6) - (lw << 1);
      SUB_IN_EC_NEG:  n = LAYER_W'(2) - (lw << 1);
      SUB_OI_EC_NEG:  n = LAYER_W'(14) - (lw << 1);
      SUB_OI_EC_POS:  n = lw << 1;
      SUB_OUT_EC_NEG: n = LAYER_W'(8) - (lw << 1);
      default:        n = lw;
    endcase
    return n;
  endfunction

  // Ladder count; zero means no entry
  function automatic logic [CNT_W-1:0] ladder_count(sub_e sub, logic [7:0] l,
                                                    logic [1:0] sch);
    logic [CNT_W-1:0] c;
    c = '0;
    case (sub)
      SUB_VTX_BAR: begin
        case (sch)
          SCHEMA_0: if (l <= 8'd7) c = CNT_VTX_BAR;
          SCHEMA_1: if (l inside {8'd0, 8'd1, 8'd2, 8'd4, 8'd6}) c = CNT_VTX_BAR;
          SCHEMA_2: if (l <= 8'd6 && !l[0]) c = CNT_VTX_BAR;
          default:  if (l <= 8'd8 && !l[0]) c = CNT_VTX_BAR;
        endcase
      end
      SUB_IN_BAR:  if (l <= 8'd1) c = CNT_IN_BAR;
      SUB_OI_BAR:  if (l == 8'd2) c = CNT_OI_BAR;
      SUB_OUT_BAR: if (l <= 8'd2) c = CNT_OUT_BAR;
      SUB_IN_EC_POS, SUB_IN_EC_NEG: if (l == 8'd0) c = CNT_IN_EC;
      SUB_OI_EC_POS, SUB_OI_EC_NEG: if (l inside {[8'd1:8'd6]}) c = CNT_OI_EC;
      SUB_OUT_EC_POS, SUB_OUT_EC_NEG: if (l <= 8'd7) c = CNT_OUT_EC;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/dcgid_decode.sv =====
// ---------------------------------------------------------------------------
// dcgid_decode
// Stage 1: remap inner subsystems, apply the side and classify the word.
// ---------------------------------------------------------------------------
module dcgid_decode
  import dcgid_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [7:0]        system_index_i,
  input  logic [7:0]        layer_index_i,
  input  logic signed [1:0] side_sign_i,
  input  logic [LAD_W-1:0]  ladder_index_i,
  input  logic [LAD_W-1:0]  module_index_i,
  input  logic [1:0]        schema_i,
  output logic              valid_o,
  input  logic              ready_i,
  output dec_t              dec_o
);

`include "detector_cell_to_geometry_id_assert.svh"

  logic       valid_q;
  dec_t       dec_q, dec_d;
  logic [7:0] sys;
  logic       neg;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign dec_o   = dec_q;

  always_comb begin
    sys = system_index_i;
    if (system_index_i == SYS_IN_BAR && layer_index_i == 8'd2) begin
      sys = SYS_OI_BAR;
    end
    if (system_index_i == SYS_IN_EC && layer_index_i != 8'd0) begin
      sys = SYS_OI_EC;
    end
    neg = side_sign_i[1];

    dec_d.s_byte     = neg ? (~sys + 8'd1) : sys;
    dec_d.layer      = layer_index_i;
    dec_d.ladder     = ladder_index_i;
    dec_d.module_idx = module_index_i;
    dec_d.schema     = schema_i;

    // barrels on the negative side have no volume of their own
    case (sys)
      SYS_VTX_BAR: dec_d.sub = neg ? SUB_UNMAPPED   : SUB_VTX_BAR;
      SYS_VTX_EC:  dec_d.sub = neg ? SUB_VTX_EC_NEG : SUB_VTX_EC_POS;
      SYS_IN_BAR:  dec_d.sub = neg ? SUB_UNMAPPED   : SUB_IN_BAR;
      SYS_IN_EC:   dec_d.sub = neg ? SUB_IN_EC_NEG  : SUB_IN_EC_POS;
      SYS_OUT_BAR: dec_d.sub = neg ? SUB_UNMAPPED   : SUB_OUT_BAR;
      SYS_OUT_EC:  dec_d.sub = neg ? SUB_OUT_EC_NEG : SUB_OUT_EC_POS;
      SYS_OI_BAR:  dec_d.sub = neg ? SUB_UNMAPPED   : SUB_OI_BAR;
      SYS_OI_EC:   dec_d.sub = neg ? SUB_OI_EC_NEG  : SUB_OI_EC_POS;
      default:     dec_d.sub = SUB_UNMAPPED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      dec_q <= dec_d;
    end
  end

  `DCGID_ASSERT_IMPL(a_oi_bar_byte, clk_i, rst_ni,
                     valid_q && dec_q.sub == SUB_OI_BAR,
                     dec_q.s_byte == SYS_OI_BAR,
                     "outer-inner barrel word with a wrong subsystem byte")
  `DCGID_ASSERT_IMPL(a_in_ec_layer, clk_i, rst_ni,
                     valid_q && (dec_q.sub == SUB_IN_EC_POS || dec_q.sub == SUB_IN_EC_NEG),
                     dec_q.layer == 8'd0,
                     "inner endcap word with nonzero layer was not remapped")
  `DCGID_ASSERT_IMPL(a_oi_ec_byte, clk_i, rst_ni,
                     valid_q && dec_q.sub == SUB_OI_EC_POS,
                     dec_q.s_byte == SYS_OI_EC,
                     "outer-inner endcap word with a wrong subsystem byte")

endmodule

// ===== sv/dcgid_lookup.sv =====
// ---------------------------------------------------------------------------
// dcgid_lookup
// Stage 2: volume, layer number and ladder count tables, ladder multiply.
// ---------------------------------------------------------------------------
module dcgid_lookup
  import dcgid_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  dec_t dec_i,
  output logic valid_o,
  input  logic ready_i,
  output lk_t  lk_o
);

  logic             valid_q;
  lk_t              lk_q, lk_d;
  logic [CNT_W-1:0] cnt;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign lk_o    = lk_q;

  always_comb begin
    cnt              = ladder_count(dec_i.sub, dec_i.layer, dec_i.schema);
    lk_d.volume      = volume_of(dec_i.sub, dec_i.s_byte);
    lk_d.layer_num   = layer_of(dec_i.sub, dec_i.layer, dec_i.schema);
    lk_d.module_idx  = dec_i.module_idx;
    lk_d.product     = PROD_W'(cnt) * PROD_W'(dec_i.ladder);
    lk_d.needs_cnt   = !(dec_i.sub == SUB_UNMAPPED || dec_i.sub == SUB_VTX_EC_POS ||
                         dec_i.sub == SUB_VTX_EC_NEG);
    lk_d.err         = lk_d.needs_cnt && (cnt == '0);
    // sensitive number for words that take no ladder count
    case (dec_i.sub)
      SUB_VTX_EC_NEG: lk_d.sen_base = SEN_W'(16) - SEN_W'(dec_i.module_idx);
      SUB_VTX_EC_POS: lk_d.sen_base = SEN_W'(dec_i.module_idx) + SEN_W'(1);
      default:        lk_d.sen_base = SEN_W'(dec_i.ladder);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      lk_q <= lk_d;
    end
  end

endmodule

// ===== sv/dcgid_pack.sv =====
// ---------------------------------------------------------------------------
// dcgid_pack
// Stage 3: finish the sensitive number and pack the identifier word.
// ---------------------------------------------------------------------------
module dcgid_pack
  import dcgid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  lk_t         lk_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [63:0] packed_id_o,
  output logic        lookup_error_o
);

  logic             valid_q;
  logic [63:0]      id_q, id_d;
  logic             err_q;
  logic [SEN_W-1:0] sen;

  assign ready_o        = !valid_q || ready_i;
  assign valid_o        = valid_q;
  assign packed_id_o    = id_q;
  assign lookup_error_o = err_q;

  always_comb begin
    sen = lk_i.needs_cnt ? SEN_W'(lk_i.product) + SEN_W'(lk_i.module_idx) + SEN_W'(1)
                         : lk_i.sen_base;
    id_d = {lk_i.volume, 56'd0} | {lk_i.layer_num, 36'd0} | {sen, 8'd0};
    // drop the word to zero when the ladder count is missing
    if (lk_i.err) begin
      id_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      id_q  <= id_d;
      err_q <= lk_i.err;
    end
  end

endmodule

// ===== sv/detector_cell_to_geometry_id.sv =====
// Each accepted word passes the decode, lookup and pack registers in turn.
// Throughput: one word per cycle while out_stall_i is low; decode, table lookup
// with the ladder multiply, and packing each take one register stage; a stall
// holds only full stages. Reset clears all stage valid bits, sets schema_q to 0.
// ---------------------------------------------------------------------------
// detector_cell_to_geometry_id
// Maps decoded tracker cell indices to a packed 64-bit geometry identifier.
// ---------------------------------------------------------------------------
module detector_cell_to_geometry_id
  import dcgid_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        system_index_i,
  input  logic [7:0]        layer_index_i,
  input  logic signed [1:0] side_sign_i,
  input  logic [9:0]        ladder_index_i,
  input  logic [9:0]        module_index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [63:0]       packed_id_o,
  output logic              lookup_error_o
);

`include "detector_cell_to_geometry_id_assert.svh"

  logic [1:0] schema_q;
  logic       in_ready;
  logic       dec_valid, dec_ready;
  dec_t       dec;
  logic       lk_valid, lk_ready;
  lk_t        lk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      schema_q <= SCHEMA_0;
    end else if (cfg_we_i) begin
      schema_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = !in_ready;

  dcgid_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_valid_i),
    .ready_o        (in_ready),
    .system_index_i (system_index_i),
    .layer_index_i  (layer_index_i),
    .side_sign_i    (side_sign_i),
    .ladder_index_i (ladder_index_i),
    .module_index_i (module_index_i),
    .schema_i       (schema_q),
    .valid_o        (dec_valid),
    .ready_i        (dec_ready),
    .dec_o          (dec)
  );

  dcgid_lookup u_lookup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .dec_i   (dec),
    .valid_o (lk_valid),
    .ready_i (lk_ready),
    .lk_o    (lk)
  );

  dcgid_pack u_pack (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (lk_valid),
    .ready_o        (lk_ready),
    .lk_i           (lk),
    .valid_o        (out_valid_o),
    .ready_i        (!out_stall_i),
    .packed_id_o    (packed_id_o),
    .lookup_error_o (lookup_error_o)
  );

  `DCGID_ASSERT_IMPL(a_err_zero_id, clk_i, rst_ni,
                     out_valid_o && lookup_error_o,
                     packed_id_o == 64'd0,
                     "lookup error word carries a nonzero identifier")
  `DCGID_ASSERT_IMPL(a_empty_out_no_stall, clk_i, rst_ni,
                     !out_valid_o,
                     !in_stall_o,
                     "input stalled while output stage is empty")
  `DCGID_ASSERT_IMPL(a_free_out_no_stall, clk_i, rst_ni,
                     !out_stall_i,
                     !in_stall_o,
                     "input stalled while output side takes words")

endmodule
